/* design/pbdc_pkg.sv */
// pbdc_pkg: shared constants and types for the pll band and divider calculator
// no dependencies; imported by every module of the block
`default_nettype none

package pbdc_pkg;

    localparam int FREQ_W        = 30;
    localparam int XTAL_W        = 25;
    localparam int PFD_W         = XTAL_W - 1;
    localparam int BAND_W        = 3;
    localparam int BAND_PROP_W   = 4;
    localparam int INT_DIV_W     = 7;
    localparam int FRAC_OUT_W    = 20;
    localparam int FRAC_BITS_DEF = 19;

    localparam logic [XTAL_W-1:0] XTAL_RESET = XTAL_W'(30000000);

    localparam logic [FREQ_W-1:0] FREQ_MIN_HZ = FREQ_W'(119000000);
    localparam logic [FREQ_W-1:0] FREQ_MAX_HZ = FREQ_W'(1050000000);
    localparam logic [FREQ_W-1:0] THR_DIV6    = FREQ_W'(705000000);
    localparam logic [FREQ_W-1:0] THR_DIV8    = FREQ_W'(525000000);
    localparam logic [FREQ_W-1:0] THR_DIV12   = FREQ_W'(353000000);
    localparam logic [FREQ_W-1:0] THR_DIV16   = FREQ_W'(239000000);
    localparam logic [FREQ_W-1:0] THR_DIV24   = FREQ_W'(177000000);

    // floor(x/3) = (x * ceil(2^25/3)) >> 25, exact for any 25-bit x
    localparam int                DIV3_SHIFT = XTAL_W;
    localparam logic [PFD_W-1:0]  DIV3_MAGIC = PFD_W'(24'hAAAAAB);

    localparam logic [BAND_PROP_W-1:0] SYNTH_SELECT = BAND_PROP_W'(8);
    localparam int                     Q_LIMIT      = 128;

    typedef enum logic [BAND_W-1:0] {
        BAND_DIV4  = 3'd0,
        BAND_DIV6  = 3'd1,
        BAND_DIV8  = 3'd2,
        BAND_DIV12 = 3'd3,
        BAND_DIV16 = 3'd4,
        BAND_DIV24 = 3'd5
    } band_t;

    typedef struct packed {
        logic  valid;
        logic  err;
        band_t band;
    } stage_ctrl_t;

endpackage

`default_nettype wire

/* design/pll_band_and_divider_calc.sv */
// pll_band_and_divider_calc: top level, front stage, chain of divider cells, result stage
// depends on pbdc_pkg, pbdc_front, pbdc_div_cell, pbdc_back
//
// Takes one frequency word per cycle and returns its band, band property, integer and
// fractional divider words after one front stage, 30+FRAC_BITS long-division cells and
// one result stage; a new word can enter every cycle that busy is low. done marks each
// result for exactly one cycle and cannot be held off, so the receiver must take it then.
// busy is high for one cycle after reset and after each crystal write, while the
// divide-by-three reciprocal of the crystal is refreshed; cfg_ready is always high.
`default_nettype none

module pll_band_and_divider_calc #(
    parameter int FRAC_BITS = pbdc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pbdc_pkg::FREQ_W-1:0]   freq_hz,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pbdc_pkg::XTAL_W-1:0]   xtal_hz,
    output logic                               done,
    output logic [pbdc_pkg::BAND_W-1:0]        band,
    output logic [pbdc_pkg::BAND_PROP_W-1:0]   band_property,
    output logic [pbdc_pkg::INT_DIV_W-1:0]     int_divider,
    output logic [pbdc_pkg::FRAC_OUT_W-1:0]    frac_divider,
    output logic                               range_error
);
    import pbdc_pkg::*;

    localparam int WORD_W  = FREQ_W + FRAC_BITS;
    localparam int STEPS   = FREQ_W + FRAC_BITS;
    localparam int LATENCY = STEPS + 2;

    logic accept;
    logic cfg_write;

    stage_ctrl_t       ctrl_chain [STEPS+1];
    logic [PFD_W-1:0]  pfd_chain  [STEPS+1];
    logic [PFD_W-1:0]  rem_chain  [STEPS+1];
    logic [WORD_W-1:0] word_chain [STEPS+1];

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = start && !busy;

    pbdc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .freq_hz   (freq_hz),
        .cfg_write (cfg_write),
        .xtal_hz   (xtal_hz),
        .busy      (busy),
        .ctrl_out  (ctrl_chain[0]),
        .pfd_out   (pfd_chain[0]),
        .rem_out   (rem_chain[0]),
        .word_out  (word_chain[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        pbdc_div_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_chain[i]),
            .pfd_in   (pfd_chain[i]),
            .rem_in   (rem_chain[i]),
            .word_in  (word_chain[i]),
            .ctrl_out (ctrl_chain[i+1]),
            .pfd_out  (pfd_chain[i+1]),
            .rem_out  (rem_chain[i+1]),
            .word_out (word_chain[i+1])
        );
    end

    // final remainder is not needed once the fraction bits are out
    logic rem_unused;
    assign rem_unused = ^rem_chain[STEPS];

    pbdc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl_in       (ctrl_chain[STEPS]),
        .pfd_in        (pfd_chain[STEPS]),
        .word_in       (word_chain[STEPS]),
        .done          (done),
        .band          (band),
        .band_property (band_property),
        .int_divider   (int_divider),
        .frac_divider  (frac_divider),
        .range_error   (range_error)
    );

    a_cfg_gap: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cfg_valid && cfg_ready) |-> busy)
        else $error("item window open right after a crystal write");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word did not come out after the pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result word without a matching accepted word");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && range_error) |-> (band == '0 && band_property == '0
                                   && int_divider == '0 && frac_divider == '0))
        else $error("range error with nonzero result fields");

    a_prop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !range_error) |-> (band_property == BAND_PROP_W'(band) + SYNTH_SELECT))
        else $error("band property does not track band");

endmodule

`default_nettype wire

/* design/pbdc_front.sv */
// pbdc_front: crystal register, divide-by-three reciprocal, range check and band pick
// depends on pbdc_pkg; feeds the first divider cell
`default_nettype none

module pbdc_front #(
    parameter int FRAC_BITS = pbdc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic [pbdc_pkg::FREQ_W-1:0]       freq_hz,
    input  wire logic                              cfg_write,
    input  wire logic [pbdc_pkg::XTAL_W-1:0]       xtal_hz,
    output logic                                   busy,
    output pbdc_pkg::stage_ctrl_t                  ctrl_out,
    output logic [pbdc_pkg::PFD_W-1:0]             pfd_out,
    output logic [pbdc_pkg::PFD_W-1:0]             rem_out,
    output logic [pbdc_pkg::FREQ_W+FRAC_BITS-1:0]  word_out
);
    import pbdc_pkg::*;

    localparam int WORD_W = FREQ_W + FRAC_BITS;
    localparam int PROD_W = XTAL_W + PFD_W;

    logic [XTAL_W-1:0] xtal_reg;
    logic [PFD_W-1:0]  pfd3_reg;
    logic              busy_reg;
    stage_ctrl_t       ctrl_reg, ctrl_next;
    logic [PFD_W-1:0]  pfd_reg, pfd_next;
    logic [WORD_W-1:0] word_reg;
    logic [PROD_W-1:0] prod3;
    logic              out_of_range;

    assign prod3 = PROD_W'(xtal_reg) * PROD_W'(DIV3_MAGIC);
    assign out_of_range = (freq_hz < FREQ_MIN_HZ) || (freq_hz > FREQ_MAX_HZ);

    always_comb
    begin
        ctrl_next.valid = accept;
        ctrl_next.err   = out_of_range;
        priority if (freq_hz >= THR_DIV6)
        begin
            ctrl_next.band = BAND_DIV4;
            pfd_next       = xtal_reg[XTAL_W-1:1];
        end
        else if (freq_hz >= THR_DIV8)
        begin
            ctrl_next.band = BAND_DIV6;
            pfd_next       = pfd3_reg;
        end
        else if (freq_hz >= THR_DIV12)
        begin
            ctrl_next.band = BAND_DIV8;
            pfd_next       = PFD_W'(xtal_reg[XTAL_W-1:2]);
        end
        else if (freq_hz >= THR_DIV16)
        begin
            ctrl_next.band = BAND_DIV12;
            pfd_next       = PFD_W'(pfd3_reg[PFD_W-1:1]);
        end
        else if (freq_hz >= THR_DIV24)
        begin
            ctrl_next.band = BAND_DIV16;
            pfd_next       = PFD_W'(xtal_reg[XTAL_W-1:3]);
        end
        else
        begin
            ctrl_next.band = BAND_DIV24;
            pfd_next       = PFD_W'(pfd3_reg[PFD_W-1:2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xtal_reg <= XTAL_RESET;
            busy_reg <= 1'b1;
            ctrl_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                xtal_reg <= xtal_hz;
            end
            // hold off items after a crystal write while the reciprocal product settles
            busy_reg <= cfg_write;
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pfd3_reg <= prod3[DIV3_SHIFT +: PFD_W];
        pfd_reg  <= pfd_next;
        word_reg <= {freq_hz, {FRAC_BITS{1'b0}}};
    end

    assign busy     = busy_reg;
    assign ctrl_out = ctrl_reg;
    assign pfd_out  = pfd_reg;
    assign rem_out  = '0;
    assign word_out = word_reg;

endmodule

`default_nettype wire

/* design/pbdc_div_cell.sv */
// pbdc_div_cell: one restoring division step with its pipeline register
// depends on pbdc_pkg; chained once per quotient bit
`default_nettype none

module pbdc_div_cell #(
    parameter int FRAC_BITS = pbdc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pbdc_pkg::stage_ctrl_t             ctrl_in,
    input  wire logic [pbdc_pkg::PFD_W-1:0]        pfd_in,
    input  wire logic [pbdc_pkg::PFD_W-1:0]        rem_in,
    input  wire logic [pbdc_pkg::FREQ_W+FRAC_BITS-1:0] word_in,
    output pbdc_pkg::stage_ctrl_t                  ctrl_out,
    output logic [pbdc_pkg::PFD_W-1:0]             pfd_out,
    output logic [pbdc_pkg::PFD_W-1:0]             rem_out,
    output logic [pbdc_pkg::FREQ_W+FRAC_BITS-1:0]  word_out
);
    import pbdc_pkg::*;

    localparam int WORD_W = FREQ_W + FRAC_BITS;

    stage_ctrl_t       ctrl_reg;
    logic [PFD_W-1:0]  pfd_reg;
    logic [PFD_W-1:0]  rem_reg, rem_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [PFD_W:0]    trial;
    logic [PFD_W:0]    diff;
    logic              fits;

    // dividend bits leave at the top of the word, quotient bits enter at the bottom
    assign trial = {rem_in, word_in[WORD_W-1]};
    assign diff  = trial - {1'b0, pfd_in};
    assign fits  = trial >= {1'b0, pfd_in};

    always_comb
    begin
        rem_next  = fits ? diff[PFD_W-1:0] : trial[PFD_W-1:0];
        word_next = {word_in[WORD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        pfd_reg  <= pfd_in;
        rem_reg  <= rem_next;
        word_reg <= word_next;
    end

    assign ctrl_out = ctrl_reg;
    assign pfd_out  = pfd_reg;
    assign rem_out  = rem_reg;
    assign word_out = word_reg;

endmodule

`default_nettype wire

/* design/pbdc_back.sv */
// pbdc_back: divider limit check and result register
// depends on pbdc_pkg; takes the last divider cell's word
`default_nettype none

module pbdc_back #(
    parameter int FRAC_BITS = pbdc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pbdc_pkg::stage_ctrl_t             ctrl_in,
    input  wire logic [pbdc_pkg::PFD_W-1:0]        pfd_in,
    input  wire logic [pbdc_pkg::FREQ_W+FRAC_BITS-1:0] word_in,
    output logic                                   done,
    output logic [pbdc_pkg::BAND_W-1:0]            band,
    output logic [pbdc_pkg::BAND_PROP_W-1:0]       band_property,
    output logic [pbdc_pkg::INT_DIV_W-1:0]         int_divider,
    output logic [pbdc_pkg::FRAC_OUT_W-1:0]        frac_divider,
    output logic                                   range_error
);
    import pbdc_pkg::*;

    localparam int WORD_W = FREQ_W + FRAC_BITS;
    localparam int FULL_W = (FRAC_BITS + 1 > FRAC_OUT_W) ? FRAC_BITS + 1 : FRAC_OUT_W;

    logic [FREQ_W-1:0]     quot;
    logic [FULL_W-1:0]     frac_full;
    logic                  err;
    logic                  done_reg;
    logic [BAND_W-1:0]     band_reg, band_next;
    logic [BAND_PROP_W-1:0] prop_reg, prop_next;
    logic [INT_DIV_W-1:0]  int_reg, int_next;
    logic [FRAC_OUT_W-1:0] frac_reg, frac_next;
    logic                  err_reg;

    assign quot      = word_in[WORD_W-1 -: FREQ_W];
    assign frac_full = FULL_W'({1'b1, word_in[FRAC_BITS-1:0]});
    assign err       = ctrl_in.err || (pfd_in == '0) || (quot == '0)
                       || (quot > FREQ_W'(Q_LIMIT));

    always_comb
    begin
        if (err)
        begin
            band_next = '0;
            prop_next = '0;
            int_next  = '0;
            frac_next = '0;
        end
        else
        begin
            band_next = ctrl_in.band;
            prop_next = BAND_PROP_W'(ctrl_in.band) + SYNTH_SELECT;
            int_next  = INT_DIV_W'(quot - FREQ_W'(1));
            frac_next = frac_full[FRAC_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        band_reg <= band_next;
        prop_reg <= prop_next;
        int_reg  <= int_next;
        frac_reg <= frac_next;
        err_reg  <= err;
    end

    assign done          = done_reg;
    assign band          = band_reg;
    assign band_property = prop_reg;
    assign int_divider   = int_reg;
    assign frac_divider  = frac_reg;
    assign range_error   = err_reg;

endmodule

`default_nettype wire
